@@ hw/rtl/tefs_pkg.sv @@
package tefs_pkg;

  // field widths
  localparam int FUNC_W = 1;
  localparam int SX_W   = 12;
  localparam int DX_W   = 11;
  localparam int DY_W   = 9;
  localparam int X_W    = 13;

  // packed stream widths (whole bytes)
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 16;

  // state widths
  localparam int ACC_W = 45;
  localparam int INC_W = 43;

  localparam int FRACTION_BITS_DEF = 32;
  localparam int BIAS_LOW_BITS     = 11;

  localparam int X_MAX = 4095;
  localparam int X_MIN = -4096;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_SETUP = 1'b0,
    FUNC_STEP  = 1'b1
  } func_t;

endpackage

@@ hw/rtl/triangle_edge_fixed_point_stepper.sv @@
// channel  dir  handshake                tdata / tuser
// s_axis   in   s_tvalid / s_tready      start_x, delta_x, delta_y ; func
// m_axis   out  m_tvalid / m_tready      edge_x
//
// A step item passes the saturating add into the pending register and is
// then handed to the output register. A setup item stalls the input while
// the bit-serial restoring divider runs, one quotient bit a cycle.
// Reset (rst, synchronous) clears accumulator, increment and all control.
// The output register lets a new item in while a result waits; a stalled
// output holds one further result in the pending register, then input stalls.
module triangle_edge_fixed_point_stepper
  import tefs_pkg::*;
#(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // start_x[11:0], delta_x[22:12], delta_y[31:23]
  input  logic [FUNC_W-1:0]     s_tuser,   // func[0]
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata    // edge_x[12:0], zeros above
);

  localparam int MAG_W = FRACTION_BITS + DX_W;
  localparam int CNT_W = $clog2(MAG_W);
  localparam logic [ACC_W-1:0] ACC_BIAS =
    (ACC_W'(1) << FRACTION_BITS) - (ACC_W'(1) << BIAS_LOW_BITS);
  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic signed [ACC_W-1:0] XS_MAX  = ACC_W'(X_MAX);
  localparam logic signed [ACC_W-1:0] XS_MIN  = ACC_W'(X_MIN);

  typedef enum logic {
    S_IDLE,
    S_DIV
  } state_t;

  state_t                    state;
  logic signed [ACC_W-1:0]   acc;
  logic signed [INC_W-1:0]   inc;
  logic [MAG_W-1:0]          dvd;
  logic [DY_W-1:0]           rem;
  logic [DY_W-1:0]           dy_r;
  logic                      neg;
  logic [CNT_W-1:0]          cnt;
  logic                      pend;
  logic [X_W-1:0]            pend_x;
  logic [X_W-1:0]            out_x;

  // input fields
  logic signed [SX_W-1:0] start_x;
  logic signed [DX_W-1:0] delta_x;
  logic [DY_W-1:0]        delta_y;
  func_t                  func;

  assign start_x = s_tdata[SX_W-1:0];
  assign delta_x = s_tdata[SX_W+DX_W-1:SX_W];
  assign delta_y = s_tdata[SX_W+DX_W+DY_W-1:SX_W+DX_W];
  assign func    = func_t'(s_tuser);

  logic accept;
  logic out_free;
  assign s_tready = (state == S_IDLE) && !pend;
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign m_tdata  = OUT_DATA_W'(out_x);

  // setup operands
  logic [DX_W-1:0]          abs_dx;
  logic [DY_W-1:0]          dy_eff;
  logic [DY_W-1:0]          rnd_bias;
  logic [MAG_W-1:0]         mag;
  logic signed [ACC_W-1:0]  sx_ext;
  logic signed [ACC_W-1:0]  acc_init;

  always_comb begin
    abs_dx   = delta_x[DX_W-1] ? DX_W'(-delta_x) : DX_W'(delta_x);
    dy_eff   = (delta_y == '0) ? DY_W'(1) : delta_y;
    rnd_bias = (abs_dx != '0) ? DY_W'(dy_eff - DY_W'(1)) : '0;
    // low fraction bits are empty, so the bias just fills them
    mag      = {abs_dx, FRACTION_BITS'(rnd_bias)};
    sx_ext   = {{(ACC_W-SX_W){start_x[SX_W-1]}}, start_x};
    acc_init = (sx_ext <<< FRACTION_BITS) + ACC_BIAS;
  end

  // step: saturating add, floor, clamp
  logic signed [ACC_W:0]    sum;
  logic signed [ACC_W-1:0]  sum_sat;
  logic signed [ACC_W-1:0]  int_part;
  logic [X_W-1:0]           step_x;

  always_comb begin
    sum = {acc[ACC_W-1], acc} + {{(ACC_W+1-INC_W){inc[INC_W-1]}}, inc};
    if (sum[ACC_W] != sum[ACC_W-1]) begin
      sum_sat = sum[ACC_W] ? ACC_MIN : ACC_MAX;
    end else begin
      sum_sat = sum[ACC_W-1:0];
    end
    int_part = sum_sat >>> FRACTION_BITS;
    if (int_part > XS_MAX) begin
      step_x = X_W'(XS_MAX);
    end else if (int_part < XS_MIN) begin
      step_x = X_W'(XS_MIN);
    end else begin
      step_x = int_part[X_W-1:0];
    end
  end

  // one restoring division step
  logic [DY_W:0]    trial;
  logic             q_bit;
  logic [DY_W-1:0]  rem_next;
  logic [MAG_W-1:0] dvd_next;

  always_comb begin
    trial    = {rem, dvd[MAG_W-1]};
    q_bit    = trial >= {1'b0, dy_r};
    rem_next = q_bit ? DY_W'(trial - {1'b0, dy_r}) : trial[DY_W-1:0];
    dvd_next = {dvd[MAG_W-2:0], q_bit};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      acc      <= '0;
      inc      <= '0;
      pend     <= 1'b0;
      m_tvalid <= 1'b0;
      cnt      <= '0;
    end else begin
      if (out_free) begin
        m_tvalid <= pend;
        out_x    <= pend_x;
        // an accept needs pend low, so this never meets the set below
        if (pend) begin
          pend <= 1'b0;
        end
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            pend <= 1'b1;
            if (func == FUNC_SETUP) begin
              acc    <= acc_init;
              pend_x <= X_W'(start_x);
              dvd    <= mag;
              rem    <= '0;
              dy_r   <= dy_eff;
              neg    <= delta_x[DX_W-1];
              cnt    <= CNT_W'(MAG_W - 1);
              state  <= S_DIV;
            end else begin
              acc    <= sum_sat;
              pend_x <= step_x;
            end
          end
        end
        S_DIV: begin
          dvd <= dvd_next;
          rem <= rem_next;
          cnt <= cnt - CNT_W'(1);
          if (cnt == '0) begin
            inc   <= neg ? -INC_W'(dvd_next) : INC_W'(dvd_next);
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // a setup item starts the divider
  a_setup_divides: assert property (@(posedge clk) disable iff (rst)
    (accept && func == FUNC_SETUP) |=> state == S_DIV)
    else $error("setup item did not start division");

  // remainder stays below the divisor
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> rem < dy_r)
    else $error("division remainder out of range");

  // a pending result is kept while the output register is stalled
  a_pend_kept: assert property (@(posedge clk) disable iff (rst)
    (pend && m_tvalid && !m_tready) |=> pend && $stable(pend_x))
    else $error("pending result lost");

  // every accepted item leaves a pending result
  a_accept_pend: assert property (@(posedge clk) disable iff (rst)
    accept |=> pend)
    else $error("accepted item produced no result");

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps

module tb;
  import tefs_pkg::*;

  localparam int FRAC = FRACTION_BITS_DEF;
  localparam int CYCLE_LIMIT = 600000;
  localparam int RANDOM_ITEMS = 880;
  localparam longint ACC_HI = (64'sd1 <<< (ACC_W - 1)) - 1;
  localparam longint ACC_LO = -(64'sd1 <<< (ACC_W - 1));

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_DATA_W-1:0] s_tdata = '0;
  logic [FUNC_W-1:0] s_tuser = FUNC_SETUP;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;

  // predictor state
  logic signed [ACC_W-1:0] walk_acc = '0;
  logic signed [INC_W-1:0] walk_inc = '0;

  logic signed [X_W-1:0] edge_x_q[$];

  bit gaps_on = 1'b1;
  bit stalls_on = 1'b1;
  int stall_left = 0;
  int cycles = 0;
  int fails = 0;
  int n_setup = 0;
  int n_step = 0;
  int n_checked = 0;
  int n_clamped = 0;
  int n_sent = 0;

  triangle_edge_fixed_point_stepper DUT (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int idle_len(bit enabled);
    int r;
    r = $urandom_range(0, 99);
    if (!enabled || r < 50)
      return 0;
    if (r < 90)
      return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // edge walker: new x after one item, updates walker state
  function automatic logic signed [X_W-1:0] edge_walk_predict(
    func_t f,
    logic signed [SX_W-1:0] sx,
    logic signed [DX_W-1:0] dx,
    logic [DY_W-1:0] dy
  );
    longint acc;
    longint mag_dx;
    longint unsigned mag;
    longint unsigned div;
    longint unsigned q;
    longint x;
    if (f == FUNC_SETUP) begin
      acc = (longint'(sx) <<< FRAC) + ((64'sd1 <<< FRAC) - (64'sd1 <<< BIAS_LOW_BITS));
      walk_acc = acc[ACC_W-1:0];
      mag_dx = longint'(dx);
      if (mag_dx < 0)
        mag_dx = -mag_dx;
      div = (dy == '0) ? 64'd1 : longint'(dy);
      mag = longint'(mag_dx) << FRAC;
      if (mag != 0)
        mag = mag + div - 1;
      q = mag / div;
      acc = (dx < 0) ? -longint'(q) : longint'(q);
      walk_inc = acc[INC_W-1:0];
      return X_W'(sx);
    end
    acc = longint'(walk_acc) + longint'(walk_inc);
    if (acc > ACC_HI)
      acc = ACC_HI;
    if (acc < ACC_LO)
      acc = ACC_LO;
    walk_acc = acc[ACC_W-1:0];
    x = acc >>> FRAC;
    if (x > X_MAX)
      x = X_MAX;
    if (x < X_MIN)
      x = X_MIN;
    return x[X_W-1:0];
  endfunction

  // one item onto the input stream; valid stays high into the next call if no gap
  task automatic send_item(
    func_t f,
    logic signed [SX_W-1:0] sx,
    logic signed [DX_W-1:0] dx,
    logic [DY_W-1:0] dy
  );
    int gap;
    gap = idle_len(gaps_on);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {dy, dx, sx};
    s_tuser <= f;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    edge_x_q.push_back(edge_walk_predict(f, sx, dx, dy));
    n_sent++;
    if (f == FUNC_SETUP)
      n_setup++;
    else
      n_step++;
  endtask

  task automatic send_setup(int sx, int dx, int dy);
    send_item(FUNC_SETUP, SX_W'(sx), DX_W'(dx), DY_W'(dy));
  endtask

  task automatic send_steps(int n);
    repeat (n) send_item(FUNC_STEP, SX_W'($urandom), DX_W'($urandom), DY_W'($urandom));
  endtask

  task automatic wait_drained();
    while (edge_x_q.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_tready <= 1'b0;
    end else if (!rst) begin
      stall_left <= idle_len(stalls_on);
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (edge_x_q.size() == 0) begin
        $error("edge_x: result %0d with nothing outstanding",
               $signed(m_tdata[X_W-1:0]));
        fails++;
      end else begin
        if (m_tdata[X_W-1:0] !== edge_x_q[0]) begin
          $error("edge_x: expected %0d, got %0d", edge_x_q[0],
                 $signed(m_tdata[X_W-1:0]));
          fails++;
        end
        if (edge_x_q[0] == X_MAX || edge_x_q[0] == X_MIN)
          n_clamped++;
        void'(edge_x_q.pop_front());
        n_checked++;
      end
    end
  end

  // reset values give x = 0 until the first setup
  task automatic test_step_from_reset();
    send_steps(2);
  endtask

  task automatic test_field_extremes();
    send_setup(2047, 1023, 1);    // accumulator runs into its upper bound
    send_steps(3);
    send_setup(-2048, -1024, 1);  // and into its lower bound
    send_steps(3);
    send_setup(0, 0, 0);          // zero height taken as one
    send_steps(1);
    send_setup(5, -7, 0);
    send_steps(2);
    send_setup(-1, 1, 511);       // tiny slope, rounding bias shows
    send_steps(2);
    send_setup(100, -1, 3);
    send_steps(3);
    send_setup(-2048, 1023, 511);
    send_steps(2);
  endtask

  // sender holds off until every result is back, then carries on
  task automatic test_drain_pause();
    send_setup(300, -200, 17);
    send_steps(5);
    s_tvalid <= 1'b0;
    wait_drained();
    repeat (20) @(posedge clk);
    send_steps(4);
    send_setup(-300, 200, 9);
    send_steps(3);
  endtask

  task automatic test_random_edges();
    int kind;
    int run;
    int dy;
    int start_n;
    start_n = n_sent;
    while (n_sent - start_n < RANDOM_ITEMS) begin
      // a stretch at full rate on both sides
      gaps_on = !((n_sent - start_n) < 150);
      stalls_on = gaps_on;
      kind = $urandom_range(0, 9);
      if (kind < 8) begin
        dy = $urandom_range(0, 511);
        send_setup($urandom, $urandom, dy);
        if ($urandom_range(0, 9) == 0)
          run = (dy < 40) ? dy + $urandom_range(0, 3) : $urandom_range(20, 40);
        else
          run = $urandom_range(1, 16);
        send_steps(run);
      end else if (kind == 8) begin
        send_steps($urandom_range(1, 3));
      end else begin
        send_setup($urandom, $urandom, $urandom);
        send_setup($urandom, $urandom, $urandom);
      end
    end
    gaps_on = 1'b1;
    stalls_on = 1'b1;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_step_from_reset();
    test_field_extremes();
    test_drain_pause();
    test_random_edges();
    s_tvalid <= 1'b0;
    wait_drained();
    repeat (100) @(posedge clk);
    if (edge_x_q.size() != 0) begin
      $error("edge_x: %0d results never arrived", edge_x_q.size());
      fails++;
    end
    $display("ran %0d setup and %0d step items, %0d results compared",
             n_setup, n_step, n_checked);
    $display("%0d results sat at the x range limits", n_clamped);
    if (fails == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
